/* src/l3ts_pkg.sv */
// Shared types, constants and arithmetic helpers of the 3D LUT trilinear sampler.
// Used by l3ts_prep, l3ts_fetch, l3ts_lerp and the top level; depends on nothing.
package l3ts_pkg;

   localparam int GRID_POINTS = 33;
   localparam int GRID_AREA   = GRID_POINTS * GRID_POINTS;
   localparam int TEXEL_COUNT = GRID_AREA * GRID_POINTS;
   localparam int ADDR_W      = $clog2(TEXEL_COUNT);
   localparam int AXIS_W      = $clog2(GRID_POINTS);

   localparam int CHAN_W      = 13;
   localparam int CHANNELS    = 3;
   localparam int TEXEL_W     = CHANNELS * CHAN_W;
   localparam int INDEX_W     = 16;
   localparam int COORD_W     = 17;
   localparam int FRAC_W      = 17;
   localparam int FRAC_SHIFT  = 16;
   localparam int PROD_W      = COORD_W + AXIS_W;
   localparam int HI_W        = PROD_W - FRAC_SHIFT;
   localparam int LERP_W      = CHAN_W + FRAC_W + 2;
   localparam int STEP_W      = LERP_W - FRAC_SHIFT;

   localparam int CORNERS     = 8;
   localparam int CORNER_W    = $clog2(CORNERS);
   localparam logic [CORNER_W-1:0] CORNER_LAST = CORNER_W'(CORNERS - 1);

   localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1 << FRAC_SHIFT);

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      STEP_R00,
      STEP_R10,
      STEP_R01,
      STEP_R11,
      STEP_G0,
      STEP_G1,
      STEP_B
   } step_type;

   typedef logic [CHAN_W-1:0]               chan_type;
   typedef logic [CHANNELS-1:0][CHAN_W-1:0] rgb_type;

   typedef struct packed {
      logic [AXIS_W-1:0] base;
      logic [FRAC_W-1:0] frac;
   } axis_type;

   typedef struct packed {
      command_type        command;
      logic [INDEX_W-1:0] write_index;
      rgb_type            write_texel;
      axis_type           red;
      axis_type           green;
      axis_type           blue;
   } job_type;

   typedef struct packed {
      rgb_type [CORNERS-1:0] texel;
      logic [FRAC_W-1:0]     frac_r;
      logic [FRAC_W-1:0]     frac_g;
      logic [FRAC_W-1:0]     frac_b;
   } texel_set_type;

   // Saturate to 1.0, scale by N-1, clamp the cell to N-2 and keep the rest as fraction.
   function automatic axis_type axis_split(input logic [COORD_W-1:0] coord);
      logic [COORD_W-1:0] c;
      logic [PROD_W-1:0]  prod;
      logic [HI_W-1:0]    hi;
      axis_type           split;
      c = (coord > COORD_ONE) ? COORD_ONE : coord;
      prod = PROD_W'(c) * PROD_W'(GRID_POINTS - 1);
      hi = prod[PROD_W-1:FRAC_SHIFT];
      if (hi > HI_W'(GRID_POINTS - 2)) begin
         hi = HI_W'(GRID_POINTS - 2);
      end
      split.base = hi[AXIS_W-1:0];
      split.frac = FRAC_W'(prod - (PROD_W'(hi) << FRAC_SHIFT));
      return split;
   endfunction

   function automatic logic [ADDR_W-1:0] base_address(input logic [AXIS_W-1:0] r,
                                                      input logic [AXIS_W-1:0] g,
                                                      input logic [AXIS_W-1:0] b);
      return ADDR_W'(g) * ADDR_W'(GRID_AREA) + ADDR_W'(b) * ADDR_W'(GRID_POINTS)
             + ADDR_W'(r);
   endfunction

   // Corner bits are {green, blue, red} steps of the cell.
   function automatic logic [ADDR_W-1:0] corner_offset(input logic [CORNER_W-1:0] corner);
      return (corner[2] ? ADDR_W'(GRID_AREA) : ADDR_W'(0))
             + (corner[1] ? ADDR_W'(GRID_POINTS) : ADDR_W'(0))
             + ADDR_W'(corner[0]);
   endfunction

   // a + floor((b - a) * t / 65536); the result stays between a and b.
   function automatic chan_type lerp_step(input chan_type a, input chan_type b,
                                          input logic [FRAC_W-1:0] t);
      logic signed [CHAN_W:0]   diff;
      logic signed [LERP_W-1:0] prod;
      logic [STEP_W-1:0]        sum;
      diff = $signed({1'b0, b}) - $signed({1'b0, a});
      prod = LERP_W'(diff) * LERP_W'($signed({1'b0, t}));
      sum = STEP_W'(a) + prod[LERP_W-1:FRAC_SHIFT];
      return sum[CHAN_W-1:0];
   endfunction

endpackage

/* src/l3ts_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module l3ts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/l3ts_prep.sv */
// Input stage: registers one item and splits its coordinates into cell and fraction.
// Depends on l3ts_pkg.
module l3ts_prep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [l3ts_pkg::INDEX_W-1:0]     req_write_index,
   input  logic [l3ts_pkg::CHAN_W-1:0]      req_write_red,
   input  logic [l3ts_pkg::CHAN_W-1:0]      req_write_green,
   input  logic [l3ts_pkg::CHAN_W-1:0]      req_write_blue,
   input  logic [l3ts_pkg::COORD_W-1:0]     req_red_coord,
   input  logic [l3ts_pkg::COORD_W-1:0]     req_green_coord,
   input  logic [l3ts_pkg::COORD_W-1:0]     req_blue_coord,
   output logic                             job_valid,
   output l3ts_pkg::job_type                job,
   input  logic                             job_ready
);
   import l3ts_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    accept;

   assign req_stall = valid_ff && !job_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      job_in.command     = command_type'(req_command);
      job_in.write_index = req_write_index;
      job_in.write_texel = {req_write_blue, req_write_green, req_write_red};
      job_in.red         = axis_split(req_red_coord);
      job_in.green       = axis_split(req_green_coord);
      job_in.blue        = axis_split(req_blue_coord);
   end

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (job_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = valid_ff;
   assign job       = job_ff;

endmodule

/* src/l3ts_fetch.sv */
// Texel table and read sequencer: performs writes and gathers the eight corners of a cell.
// Depends on l3ts_pkg and l3ts_ram.
module l3ts_fetch (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   input  l3ts_pkg::job_type        job,
   output logic                     job_ready,
   output logic                     set_valid,
   output l3ts_pkg::texel_set_type  set_out,
   input  logic                     set_ready
);
   import l3ts_pkg::*;

   logic                busy_ff, busy_in;
   logic [CORNER_W-1:0] corner_ff, corner_in;
   logic [ADDR_W-1:0]   base_ff;
   logic [FRAC_W-1:0]   frac_r_ff, frac_g_ff, frac_b_ff;
   logic                rd_valid_ff;
   logic [CORNER_W-1:0] rd_corner_ff;
   logic                gat_full_ff, gat_full_in;
   rgb_type             gather_ff [CORNERS];

   logic                job_take, is_start, is_write, rd_last, gat_free;
   logic [ADDR_W-1:0]   start_base, ram_addr;
   logic                ram_re;
   logic [CORNER_W-1:0] issue_corner;
   rgb_type             rd_data;

   assign start_base = base_address(job.red.base, job.green.base, job.blue.base);
   assign rd_last    = rd_valid_ff && (rd_corner_ff == CORNER_LAST);
   assign set_valid  = gat_full_ff || rd_last;
   assign gat_free   = !set_valid || set_ready;
   assign job_ready  = !busy_ff && ((job.command == CMD_WRITE) || gat_free);
   assign job_take   = job_valid && job_ready;
   assign is_start   = job_take && (job.command == CMD_SAMPLE);
   // Drop writes beyond the table.
   assign is_write   = job_take && (job.command == CMD_WRITE)
                       && (int'(job.write_index) < TEXEL_COUNT);

   assign ram_re       = is_start || busy_ff;
   assign issue_corner = busy_ff ? corner_ff : CORNER_W'(0);

   always_comb begin
      priority if (busy_ff) begin
         ram_addr = base_ff + corner_offset(corner_ff);
      end else if (is_start) begin
         ram_addr = start_base;
      end else begin
         ram_addr = ADDR_W'(job.write_index);
      end
   end

   l3ts_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (TEXEL_COUNT)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (is_write),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (job.write_texel),
      .rd_data (rd_data)
   );

   always_comb begin
      priority if (is_start) begin
         busy_in   = 1'b1;
         corner_in = CORNER_W'(1);
      end else if (busy_ff) begin
         busy_in   = (corner_ff != CORNER_LAST);
         corner_in = corner_ff + CORNER_W'(1);
      end else begin
         busy_in   = 1'b0;
         corner_in = corner_ff;
      end
   end

   // The last corner goes straight from the RAM when the interpolator takes it at once.
   always_comb begin
      priority if (set_valid && set_ready) begin
         gat_full_in = 1'b0;
      end else if (rd_last) begin
         gat_full_in = 1'b1;
      end else begin
         gat_full_in = gat_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         corner_ff   <= '0;
         rd_valid_ff <= 1'b0;
         gat_full_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         corner_ff   <= corner_in;
         rd_valid_ff <= ram_re;
         gat_full_ff <= gat_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_corner_ff <= issue_corner;
      if (is_start) begin
         base_ff   <= start_base;
         frac_r_ff <= job.red.frac;
         frac_g_ff <= job.green.frac;
         frac_b_ff <= job.blue.frac;
      end
      for (int k = 0; k < CORNERS; k++) begin
         if (rd_valid_ff && (rd_corner_ff == CORNER_W'(k))) begin
            gather_ff[k] <= rd_data;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < CORNERS - 1; k++) begin
         set_out.texel[k] = gather_ff[k];
      end
      set_out.texel[CORNERS-1] = gat_full_ff ? gather_ff[CORNERS-1] : rd_data;
      set_out.frac_r = frac_r_ff;
      set_out.frac_g = frac_g_ff;
      set_out.frac_b = frac_b_ff;
   end

endmodule

/* src/l3ts_lerp.sv */
// Shared interpolation unit: seven lerp steps over three channel lanes, plus output register.
// Depends on l3ts_pkg.
module l3ts_lerp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             set_valid,
   input  l3ts_pkg::texel_set_type          set_in,
   output logic                             set_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [l3ts_pkg::CHAN_W-1:0]      rsp_out_red,
   output logic [l3ts_pkg::CHAN_W-1:0]      rsp_out_green,
   output logic [l3ts_pkg::CHAN_W-1:0]      rsp_out_blue
);
   import l3ts_pkg::*;

   logic          busy_ff, busy_in;
   step_type      step_ff, step_in;
   texel_set_type set_ff;
   rgb_type       v00_ff, v10_ff, v01_ff, v11_ff, lo_ff, hi_ff;
   rgb_type       out_ff;
   logic          out_valid_ff, out_valid_in;

   logic              out_free, finish, load;
   rgb_type           lane_a, lane_b, lane_y;
   logic [FRAC_W-1:0] lane_t;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign finish    = busy_ff && (step_ff == STEP_B) && out_free;
   assign set_ready = !busy_ff || finish;
   assign load      = set_valid && set_ready;

   // Next step.
   always_comb begin
      priority if (load) begin
         busy_in = 1'b1;
         step_in = STEP_R00;
      end else if (finish) begin
         busy_in = 1'b0;
         step_in = step_ff;
      end else if (busy_ff && (step_ff != STEP_B)) begin
         busy_in = 1'b1;
         step_in = step_type'(step_ff + 3'd1);
      end else begin
         busy_in = busy_ff;
         step_in = step_ff;
      end
   end

   always_comb begin
      priority if (finish) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Operand selection: red pairs first, then green, then blue.
   always_comb begin
      lane_a = '0;
      lane_b = '0;
      lane_t = '0;
      unique case (step_ff)
         STEP_R00: begin
            lane_a = set_ff.texel[0];
            lane_b = set_ff.texel[1];
            lane_t = set_ff.frac_r;
         end
         STEP_R10: begin
            lane_a = set_ff.texel[4];
            lane_b = set_ff.texel[5];
            lane_t = set_ff.frac_r;
         end
         STEP_R01: begin
            lane_a = set_ff.texel[2];
            lane_b = set_ff.texel[3];
            lane_t = set_ff.frac_r;
         end
         STEP_R11: begin
            lane_a = set_ff.texel[6];
            lane_b = set_ff.texel[7];
            lane_t = set_ff.frac_r;
         end
         STEP_G0: begin
            lane_a = v00_ff;
            lane_b = v10_ff;
            lane_t = set_ff.frac_g;
         end
         STEP_G1: begin
            lane_a = v01_ff;
            lane_b = v11_ff;
            lane_t = set_ff.frac_g;
         end
         STEP_B: begin
            lane_a = lo_ff;
            lane_b = hi_ff;
            lane_t = set_ff.frac_b;
         end
         default: begin
         end
      endcase
      for (int k = 0; k < CHANNELS; k++) begin
         lane_y[k] = lerp_step(lane_a[k], lane_b[k], lane_t);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_R00;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         set_ff <= set_in;
      end
      if (finish) begin
         out_ff <= lane_y;
      end
      if (busy_ff) begin
         unique case (step_ff)
            STEP_R00: v00_ff <= lane_y;
            STEP_R10: v10_ff <= lane_y;
            STEP_R01: v01_ff <= lane_y;
            STEP_R11: v11_ff <= lane_y;
            STEP_G0:  lo_ff  <= lane_y;
            STEP_G1:  hi_ff  <= lane_y;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];

endmodule

/* src/lut3d_trilinear_sampler_core.sv */
// Top level of the 3D LUT trilinear sampler: input stage, texel table with read
// sequencer, and interpolation unit. Depends on l3ts_pkg, l3ts_prep, l3ts_fetch, l3ts_lerp.
//
//   Channel  Direction  Handshake           Moves
//   req_     in         req_valid/req_stall texel write or sample item
//   rsp_     out        rsp_valid/rsp_stall interpolated RGB item, one per sample
//
// A sample item occupies the single table port for eight texel reads, one per corner,
// and no item is taken until its last read is issued; a write takes one port access.
// Reset clears only control state; the table is undefined until written.
// A stalled result holds the interpolator, which in turn stops the next set of reads.
module lut3d_trilinear_sampler_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_command,
   input  logic [l3ts_pkg::INDEX_W-1:0]     req_write_index,
   input  logic [l3ts_pkg::CHAN_W-1:0]      req_write_red,
   input  logic [l3ts_pkg::CHAN_W-1:0]      req_write_green,
   input  logic [l3ts_pkg::CHAN_W-1:0]      req_write_blue,
   input  logic [l3ts_pkg::COORD_W-1:0]     req_red_coord,
   input  logic [l3ts_pkg::COORD_W-1:0]     req_green_coord,
   input  logic [l3ts_pkg::COORD_W-1:0]     req_blue_coord,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [l3ts_pkg::CHAN_W-1:0]      rsp_out_red,
   output logic [l3ts_pkg::CHAN_W-1:0]      rsp_out_green,
   output logic [l3ts_pkg::CHAN_W-1:0]      rsp_out_blue
);
   import l3ts_pkg::*;

   logic          job_valid, job_ready;
   job_type       job;
   logic          set_valid, set_ready;
   texel_set_type texel_set;

   l3ts_prep u_prep (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_write_index (req_write_index),
      .req_write_red   (req_write_red),
      .req_write_green (req_write_green),
      .req_write_blue  (req_write_blue),
      .req_red_coord   (req_red_coord),
      .req_green_coord (req_green_coord),
      .req_blue_coord  (req_blue_coord),
      .job_valid       (job_valid),
      .job             (job),
      .job_ready       (job_ready)
   );

   l3ts_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready),
      .set_valid (set_valid),
      .set_out   (texel_set),
      .set_ready (set_ready)
   );

   l3ts_lerp u_lerp (
      .clock         (clock),
      .reset         (reset),
      .set_valid     (set_valid),
      .set_in        (texel_set),
      .set_ready     (set_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

endmodule
